[hdl/mrt_pkg.sv]
// shared types and constants for the mode registry with transition timer
package mrt_pkg;

    localparam int MODE_SLOTS_DEF   = 16;
    localparam int MODE_ID_BITS_DEF = 8;
    localparam int ID_FIELD_W       = 8;
    localparam int DUR_W            = 16;

    typedef logic [ID_FIELD_W-1:0] mode_id_t;
    typedef logic [DUR_W-1:0]      dur_t;

    localparam logic [1:0] OP_REGISTER = 2'd0;
    localparam logic [1:0] OP_SWITCH   = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;
    localparam logic [1:0] OP_NONE     = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_DUP     = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    localparam dur_t DUR_MAX = '1;

    typedef struct packed {
        logic [1:0] mode;
        mode_id_t   mode_id;
        dur_t       settle_ms;
        dur_t       tick_ms;
    } item_t;

    typedef struct packed {
        logic [1:0] status;
        mode_id_t   current_mode;
        mode_id_t   previous_mode;
        logic       exit_hook;
        logic       enter_hook;
        logic       mode_changed;
        logic       transition_event;
        logic       tick_hook;
        logic       transitioning;
    } result_t;

    typedef struct packed {
        logic load;
        logic compare;
        logic advance;
        logic execute;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       full;
        logic       empty;
        logic       match;
        logic       last;
    } ctrl_stat_t;

endpackage

[hdl/mrt_ctrl.sv]
// controller state machine: item load, slot scan sequencing and execute
module mrt_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  mrt_pkg::ctrl_stat_t  stat,
    output mrt_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_READ  = 5'b00100,
        S_CMP   = 5'b01000,
        S_EXEC  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.op == mrt_pkg::OP_REGISTER && stat.full)
                begin
                    state_next = S_EXEC;
                end
                else if ((stat.op == mrt_pkg::OP_REGISTER || stat.op == mrt_pkg::OP_SWITCH)
                         && !stat.empty)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_EXEC;
                end
            end
            S_READ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                cmd.compare = 1'b1;
                if (stat.match || stat.last)
                begin
                    state_next = S_EXEC;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

[hdl/mrt_datapath.sv]
// datapath: mode table memory, scan index, current mode and transition timer
module mrt_datapath #(
    parameter int MODE_SLOTS   = mrt_pkg::MODE_SLOTS_DEF,
    parameter int MODE_ID_BITS = mrt_pkg::MODE_ID_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mrt_pkg::item_t       item,
    input  mrt_pkg::ctrl_cmd_t   cmd,
    output mrt_pkg::ctrl_stat_t  stat,
    output logic                 done,
    output mrt_pkg::result_t     result
);

    localparam int IdW   = (MODE_ID_BITS < mrt_pkg::ID_FIELD_W) ?
                           MODE_ID_BITS : mrt_pkg::ID_FIELD_W;
    localparam int IdxW  = (MODE_SLOTS > 1) ? $clog2(MODE_SLOTS) : 1;
    localparam int CntW  = $clog2(MODE_SLOTS + 1);
    localparam int EntW  = IdW + mrt_pkg::DUR_W;

    typedef logic [IdW-1:0]  id_t;
    typedef logic [CntW-1:0] cnt_t;

    // mode table memory
    logic [EntW-1:0] table_mem [MODE_SLOTS];
    logic [EntW-1:0] rd_data_reg;

    logic [1:0]      op_reg;
    id_t             id_reg;
    mrt_pkg::dur_t   tdur_reg;
    mrt_pkg::dur_t   tick_reg;

    logic [IdxW-1:0] idx_reg;
    logic            found_reg;
    mrt_pkg::dur_t   found_dur_reg;

    cnt_t            count_reg;
    id_t             active_reg;
    logic            active_known_reg;
    logic            in_trans_reg;
    mrt_pkg::dur_t   elapsed_reg;
    mrt_pkg::dur_t   duration_reg;

    cnt_t            count_next;
    id_t             active_next;
    logic            active_known_next;
    logic            in_trans_next;
    mrt_pkg::dur_t   elapsed_next;
    mrt_pkg::dur_t   duration_next;
    logic            wr_en;
    mrt_pkg::result_t result_next;

    logic            done_reg;
    mrt_pkg::result_t result_reg;

    logic [mrt_pkg::DUR_W:0] tick_sum;
    mrt_pkg::dur_t   tick_sat;
    id_t             rd_id;
    mrt_pkg::dur_t   rd_dur;

    assign rd_id  = rd_data_reg[EntW-1:mrt_pkg::DUR_W];
    assign rd_dur = rd_data_reg[mrt_pkg::DUR_W-1:0];

    assign stat.op    = op_reg;
    assign stat.full  = (count_reg == cnt_t'(MODE_SLOTS));
    assign stat.empty = (count_reg == '0);
    assign stat.match = (rd_id == id_reg);
    assign stat.last  = (cnt_t'(idx_reg) == count_reg - cnt_t'(1));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[count_reg[IdxW-1:0]] <= {id_reg, tdur_reg};
        end
        rd_data_reg <= table_mem[idx_reg];
    end

    // item and scan registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= item.mode;
            id_reg   <= item.mode_id[IdW-1:0];
            tdur_reg <= item.settle_ms;
            tick_reg <= item.tick_ms;
            idx_reg  <= '0;
        end
        else if (cmd.advance)
        begin
            idx_reg <= idx_reg + IdxW'(1);
        end
        if (cmd.compare && stat.match)
        begin
            found_dur_reg <= rd_dur;
        end
        result_reg <= result_next;
    end

    assign tick_sum = {1'b0, elapsed_reg} + {1'b0, tick_reg};
    assign tick_sat = tick_sum[mrt_pkg::DUR_W] ? mrt_pkg::DUR_MAX
                                               : tick_sum[mrt_pkg::DUR_W-1:0];

    always_comb
    begin
        count_next        = count_reg;
        active_next       = active_reg;
        active_known_next = active_known_reg;
        in_trans_next     = in_trans_reg;
        elapsed_next      = elapsed_reg;
        duration_next     = duration_reg;
        wr_en             = 1'b0;
        result_next       = '0;
        result_next.status = mrt_pkg::ST_OK;
        case (op_reg)
            mrt_pkg::OP_REGISTER:
            begin
                if (stat.full)
                begin
                    result_next.status = mrt_pkg::ST_FULL;
                end
                else if (found_reg)
                begin
                    result_next.status = mrt_pkg::ST_DUP;
                end
                else
                begin
                    wr_en      = cmd.execute;
                    count_next = count_reg + cnt_t'(1);
                    if (id_reg == active_reg)
                    begin
                        active_known_next = 1'b1;
                    end
                end
            end
            mrt_pkg::OP_SWITCH:
            begin
                if (!found_reg)
                begin
                    result_next.status = mrt_pkg::ST_MISSING;
                end
                else
                begin
                    result_next.exit_hook    = active_known_reg;
                    result_next.enter_hook   = 1'b1;
                    result_next.mode_changed = 1'b1;
                    active_next              = id_reg;
                    active_known_next        = 1'b1;
                    if (found_dur_reg != '0)
                    begin
                        in_trans_next = 1'b1;
                        elapsed_next  = '0;
                        duration_next = found_dur_reg;
                    end
                end
            end
            mrt_pkg::OP_TICK:
            begin
                if (in_trans_reg)
                begin
                    elapsed_next = tick_sat;
                    if (tick_sat >= duration_reg)
                    begin
                        in_trans_next = 1'b0;
                    end
                    result_next.transition_event = 1'b1;
                end
                result_next.tick_hook = active_known_reg;
            end
            default:
            begin
            end
        endcase
        result_next.current_mode  = mrt_pkg::mode_id_t'(active_next);
        result_next.previous_mode = mrt_pkg::mode_id_t'(active_reg);
        result_next.transitioning = in_trans_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg        <= 1'b0;
            count_reg        <= '0;
            active_reg       <= '0;
            active_known_reg <= 1'b0;
            in_trans_reg     <= 1'b0;
            elapsed_reg      <= '0;
            duration_reg     <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.execute;
            if (cmd.load)
            begin
                found_reg <= 1'b0;
            end
            else if (cmd.compare && stat.match)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.execute)
            begin
                count_reg        <= count_next;
                active_reg       <= active_next;
                active_known_reg <= active_known_next;
                in_trans_reg     <= in_trans_next;
                elapsed_reg      <= elapsed_next;
                duration_reg     <= duration_next;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[hdl/mode_registry_with_transition_timer_core.sv]
// top level of the mode registry with transition timer
//
// command channel: an item beat is taken at a rising edge with start high
// and busy low; item.mode selects register, switch or tick
// result channel: done is high for exactly one cycle with the result beat
// on result; the receiver cannot stall, so nothing is ever held back
// busy stays high while an item is checked, scanned and executed, and done
// is high in the first cycle with busy low again; the scan covers no slots
// for ticks, unused codes, an empty table or a full table on register, and
// up to the fill count for register and switch, stopping at the first match
// a new item can be taken in the same cycle that done is high; the scan
// reads the table memory one slot at a time through its registered read
// port
// reset: the fill count, current mode, transition flag and timers clear;
// table contents are not cleared and need no clearing pass
module mode_registry_with_transition_timer_core #(
    parameter int MODE_SLOTS   = mrt_pkg::MODE_SLOTS_DEF,
    parameter int MODE_ID_BITS = mrt_pkg::MODE_ID_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  mrt_pkg::item_t    item,
    output logic              done,
    output mrt_pkg::result_t  result
);

    mrt_pkg::ctrl_cmd_t  cmd;
    mrt_pkg::ctrl_stat_t stat;

    mrt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    mrt_datapath #(
        .MODE_SLOTS   (MODE_SLOTS),
        .MODE_ID_BITS (MODE_ID_BITS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .done   (done),
        .result (result)
    );

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without a preceding busy item");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat longer than one cycle");

    a_exit_needs_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.exit_hook) |-> (result.enter_hook && result.status == mrt_pkg::ST_OK))
        else $error("exit hook without a successful switch");

endmodule

[bench/tb_mode_registry_with_transition_timer_core.sv]
// self-checking testbench for the mode registry with transition timer core
`timescale 1ns / 1ps

module tb_mode_registry_with_transition_timer_core;

    localparam int SLOTS       = mrt_pkg::MODE_SLOTS_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_GAP     = 40;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    mrt_pkg::item_t   item_in;
    logic             done;
    mrt_pkg::result_t result;

    // predicted registry state
    mrt_pkg::mode_id_t tbl_ids [SLOTS];
    mrt_pkg::dur_t     tbl_dur [SLOTS];
    int                tbl_count;
    mrt_pkg::mode_id_t cur_mode;
    logic              in_trans;
    mrt_pkg::dur_t     elapsed;
    mrt_pkg::dur_t     duration;

    mrt_pkg::result_t pending_results[$];
    int       idle_pct;
    int       stall_cycles;
    int       n_issued;
    int       n_checked;
    int       n_errors;
    int       n_switches;
    int       n_completed;
    int       n_full;
    int       n_dup;
    int       n_missing;

    mode_registry_with_transition_timer_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item_in),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int find_slot(mrt_pkg::mode_id_t id);
        for (int i = 0; i < tbl_count; i++)
        begin
            if (tbl_ids[i] == id)
                return i;
        end
        return -1;
    endfunction

    function automatic mrt_pkg::result_t registry_step(mrt_pkg::item_t cmd);
        mrt_pkg::result_t r;
        int               hit;
        logic [16:0]      sum;
        r = '0;
        r.status = mrt_pkg::ST_OK;
        r.previous_mode = cur_mode;
        case (cmd.mode)
            mrt_pkg::OP_REGISTER:
            begin
                if (tbl_count >= SLOTS)
                begin
                    r.status = mrt_pkg::ST_FULL;
                    n_full++;
                end
                else if (find_slot(cmd.mode_id) >= 0)
                begin
                    r.status = mrt_pkg::ST_DUP;
                    n_dup++;
                end
                else
                begin
                    tbl_ids[tbl_count] = cmd.mode_id;
                    tbl_dur[tbl_count] = cmd.settle_ms;
                    tbl_count++;
                end
            end
            mrt_pkg::OP_SWITCH:
            begin
                hit = find_slot(cmd.mode_id);
                if (hit < 0)
                begin
                    r.status = mrt_pkg::ST_MISSING;
                    n_missing++;
                end
                else
                begin
                    r.exit_hook = (find_slot(cur_mode) >= 0);
                    cur_mode = cmd.mode_id;
                    r.enter_hook = 1'b1;
                    if (tbl_dur[hit] != '0)
                    begin
                        in_trans = 1'b1;
                        elapsed = '0;
                        duration = tbl_dur[hit];
                    end
                    r.mode_changed = 1'b1;
                    n_switches++;
                end
            end
            mrt_pkg::OP_TICK:
            begin
                if (in_trans)
                begin
                    sum = {1'b0, elapsed} + {1'b0, cmd.tick_ms};
                    elapsed = sum[16] ? mrt_pkg::DUR_MAX : sum[15:0];
                    if (elapsed >= duration)
                    begin
                        in_trans = 1'b0;
                        n_completed++;
                    end
                    r.transition_event = 1'b1;
                end
                r.tick_hook = (find_slot(cur_mode) >= 0);
            end
            default:
            begin
            end
        endcase
        r.current_mode = cur_mode;
        r.transitioning = in_trans;
        return r;
    endfunction

    function automatic mrt_pkg::item_t make_cmd(logic [1:0] op, mrt_pkg::mode_id_t id,
                                                mrt_pkg::dur_t dur, mrt_pkg::dur_t tk);
        mrt_pkg::item_t c;
        c.mode = op;
        c.mode_id = id;
        c.settle_ms = dur;
        c.tick_ms = tk;
        return c;
    endfunction

    function automatic mrt_pkg::item_t random_cmd(int reg_pct);
        mrt_pkg::item_t c;
        int             roll;
        c.mode_id = 8'($urandom_range(255));
        c.settle_ms = 16'($urandom_range(16'hFFFF));
        c.tick_ms = 16'($urandom_range(16'hFFFF));
        roll = $urandom_range(99);
        if (roll < reg_pct)
        begin
            c.mode = mrt_pkg::OP_REGISTER;
            if (tbl_count > 0 && $urandom_range(4) == 0)
                c.mode_id = tbl_ids[$urandom_range(tbl_count - 1)];
            case ($urandom_range(3))
                0: c.settle_ms = '0;
                1, 2: c.settle_ms = 16'($urandom_range(1, 5000));
                default: ;
            endcase
        end
        else
        begin
            roll = $urandom_range(99);
            if (roll < 4)
                c.mode = mrt_pkg::OP_NONE;
            else if (roll < 44)
            begin
                c.mode = mrt_pkg::OP_SWITCH;
                if (tbl_count > 0 && $urandom_range(9) < 8)
                    c.mode_id = tbl_ids[$urandom_range(tbl_count - 1)];
            end
            else
            begin
                c.mode = mrt_pkg::OP_TICK;
                roll = $urandom_range(9);
                if (roll < 7)
                    c.tick_ms = 16'($urandom_range(3000));
                else if (roll < 9)
                    c.tick_ms = 16'($urandom_range(255));
            end
        end
        return c;
    endfunction

    // one command beat, then an optional random gap
    task automatic issue_cmd(mrt_pkg::item_t cmd);
        int gap;
        start <= 1'b1;
        item_in <= cmd;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(registry_step(cmd));
        n_issued++;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            gap = 0;
            do
            begin
                @(posedge clk);
                gap++;
            end
            while (gap < MAX_GAP && $urandom_range(99) < idle_pct);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_special_cases();
        idle_pct = 0;
        issue_cmd(make_cmd(mrt_pkg::OP_TICK, 8'h00, 16'h0000, 16'hFFFF));
        issue_cmd(make_cmd(mrt_pkg::OP_NONE, 8'hFF, 16'hFFFF, 16'hFFFF));
        issue_cmd(make_cmd(mrt_pkg::OP_SWITCH, 8'h00, 16'h0000, 16'h0000));
        issue_cmd(make_cmd(mrt_pkg::OP_REGISTER, 8'hFF, 16'hFFFF, 16'h0000));
        issue_cmd(make_cmd(mrt_pkg::OP_REGISTER, 8'hFF, 16'h0000, 16'h0000));
        // leaving the unregistered reset mode
        issue_cmd(make_cmd(mrt_pkg::OP_SWITCH, 8'hFF, 16'h0000, 16'h0000));
        issue_cmd(make_cmd(mrt_pkg::OP_TICK, 8'h00, 16'h0000, 16'h8000));
        issue_cmd(make_cmd(mrt_pkg::OP_TICK, 8'h00, 16'h0000, 16'h7FFF));
        issue_cmd(make_cmd(mrt_pkg::OP_REGISTER, 8'h00, 16'h0000, 16'h0000));
        issue_cmd(make_cmd(mrt_pkg::OP_REGISTER, 8'h80, 16'h0001, 16'h0000));
        issue_cmd(make_cmd(mrt_pkg::OP_SWITCH, 8'h80, 16'h0000, 16'h0000));
        // switch without transition keeps the running one
        issue_cmd(make_cmd(mrt_pkg::OP_SWITCH, 8'h00, 16'h0000, 16'h0000));
        issue_cmd(make_cmd(mrt_pkg::OP_TICK, 8'h00, 16'h0000, 16'h0000));
        issue_cmd(make_cmd(mrt_pkg::OP_TICK, 8'h00, 16'h0000, 16'h0001));
        issue_cmd(make_cmd(mrt_pkg::OP_SWITCH, 8'hFF, 16'h0000, 16'h0000));
        // elapsed time saturates
        issue_cmd(make_cmd(mrt_pkg::OP_TICK, 8'h00, 16'h0000, 16'hFFF0));
        issue_cmd(make_cmd(mrt_pkg::OP_TICK, 8'h00, 16'h0000, 16'hFFF0));
        issue_cmd(make_cmd(mrt_pkg::OP_TICK, 8'h00, 16'h0000, 16'h0005));
    endtask

    task automatic test_random_fill(int count);
        idle_pct = 0;
        for (int i = 0; i < count; i++)
            issue_cmd(random_cmd(30));
    endtask

    task automatic test_full_table();
        int fresh;
        fresh = 0;
        idle_pct = 0;
        while (tbl_count < SLOTS)
            issue_cmd(make_cmd(mrt_pkg::OP_REGISTER, 8'($urandom_range(255)),
                               16'($urandom_range(1, 4000)), 16'h0000));
        for (int v = 0; v < 256; v++)
        begin
            if (find_slot(8'(v)) < 0)
            begin
                fresh = v;
                break;
            end
        end
        issue_cmd(make_cmd(mrt_pkg::OP_REGISTER, 8'(fresh), 16'h1234, 16'h0000));
        // full takes precedence over duplicate
        issue_cmd(make_cmd(mrt_pkg::OP_REGISTER, tbl_ids[0], 16'h0000, 16'h0000));
        issue_cmd(make_cmd(mrt_pkg::OP_SWITCH, 8'(fresh), 16'h0000, 16'h0000));
        issue_cmd(make_cmd(mrt_pkg::OP_SWITCH, tbl_ids[SLOTS - 1], 16'h0000, 16'h0000));
    endtask

    task automatic test_random_traffic(int count, int pct);
        idle_pct = pct;
        for (int i = 0; i < count; i++)
            issue_cmd(random_cmd(10));
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            n_errors++;
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        mrt_pkg::result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, actual %p",
                         $time, result);
                n_errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                n_checked++;
                check_field("status", 32'(want.status), 32'(result.status));
                check_field("current_mode", 32'(want.current_mode),
                            32'(result.current_mode));
                check_field("previous_mode", 32'(want.previous_mode),
                            32'(result.previous_mode));
                check_field("exit_hook", 32'(want.exit_hook), 32'(result.exit_hook));
                check_field("enter_hook", 32'(want.enter_hook), 32'(result.enter_hook));
                check_field("mode_changed", 32'(want.mode_changed),
                            32'(result.mode_changed));
                check_field("transition_event", 32'(want.transition_event),
                            32'(result.transition_event));
                check_field("tick_hook", 32'(want.tick_hook), 32'(result.tick_hook));
                check_field("transitioning", 32'(want.transitioning),
                            32'(result.transitioning));
            end
        end
    end

    // watchdog on cycles without an item beat
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy))
            stall_cycles <= 0;
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
                $display("mode_registry_with_transition_timer_core test failed");
                $finish;
            end
        end
    end

    initial
    begin
        int waited;
        rst_n <= 1'b0;
        start <= 1'b0;
        item_in <= '0;
        stall_cycles = 0;
        tbl_count = 0;
        cur_mode = '0;
        in_trans = 1'b0;
        elapsed = '0;
        duration = '0;
        idle_pct = 0;
        n_issued = 0;
        n_checked = 0;
        n_errors = 0;
        n_switches = 0;
        n_completed = 0;
        n_full = 0;
        n_dup = 0;
        n_missing = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_special_cases();
        test_random_fill(150);
        test_full_table();
        drain_results();
        test_random_traffic(450, 58);
        drain_results();
        test_random_traffic(400, 0);
        test_random_traffic(450, 20);

        start <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < 200)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (40) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived, expected 0 outstanding, actual %0d",
                     $time, pending_results.size(), pending_results.size());
            n_errors++;
        end

        $display("%0d commands sent, %0d results compared, %0d errors",
                 n_issued, n_checked, n_errors);
        $display("%0d switches, %0d transitions ended, %0d full, %0d duplicate, %0d unknown",
                 n_switches, n_completed, n_full, n_dup, n_missing);
        if (n_errors == 0)
            $display("mode_registry_with_transition_timer_core test passed");
        else
            $display("mode_registry_with_transition_timer_core test failed");
        $finish;
    end

endmodule
